// ----- hdl/fsc_pkg.sv -----
package fsc_pkg;

    // fixed field widths at the ports
    localparam int FIELD_W     = 32;
    localparam int RAD_W       = 31;
    localparam int LINE_W      = 2;

    // stream packing
    localparam int S_TDATA_W   = 256;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 8;

    // geometry
    localparam int PLANE_COUNT = 6;
    localparam int COEF_COUNT  = 4;
    localparam int AXIS_STEPS  = 3;
    localparam int PLANE_IDX_W = 3;
    localparam int STEP_W      = 2;

    // action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_TEST  = 1'b1;

    // sequencer to multiply-accumulate unit
    typedef struct packed {
        logic              start;   // new sphere: set result to inside
        logic              issue;   // one product issued this cycle
        logic              first;   // first product of a plane
        logic              last;    // last product of a plane
        logic [STEP_W-1:0] sel;     // axis / coefficient select
    } t_mac_ctrl;

endpackage

// ----- hdl/fsc_plane_store.sv -----
module fsc_plane_store
    import fsc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_load,
    input  logic [LINE_W-1:0]                        i_line,
    input  logic [3:0][VALUE_WIDTH-1:0]              i_elem,
    input  logic [PLANE_IDX_W-1:0]                   i_plane,
    output logic [COEF_COUNT-1:0][VALUE_WIDTH:0]     o_row
);

    localparam int CW = VALUE_WIDTH + 1;

    logic [COEF_COUNT-1:0][CW-1:0] r_coef [PLANE_COUNT];
    logic signed [CW-1:0]          w_e3;
    logic signed [CW-1:0]          w_ek   [AXIS_STEPS];

    always_comb begin
        w_e3 = CW'($signed(i_elem[3]));
        for (int k = 0; k < AXIS_STEPS; k++) begin
            w_ek[k] = CW'($signed(i_elem[k]));
        end
    end

    // plane 2k = e3 + ek, plane 2k+1 = e3 - ek
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PLANE_COUNT; p++) begin
                r_coef[p] <= '0;
            end
        end else if (i_load) begin
            for (int k = 0; k < AXIS_STEPS; k++) begin
                r_coef[2*k][i_line]   <= w_e3 + w_ek[k];
                r_coef[2*k+1][i_line] <= w_e3 - w_ek[k];
            end
        end
    end

    assign o_row = r_coef[i_plane];

endmodule

// ----- hdl/fsc_mac.sv -----
module fsc_mac
    import fsc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  t_mac_ctrl                            i_ctrl,
    input  logic [COEF_COUNT-1:0][VALUE_WIDTH:0] i_row,
    input  logic [AXIS_STEPS-1:0][VALUE_WIDTH-1:0] i_centre,
    input  logic [VALUE_WIDTH-2:0]               i_radius,
    output logic                                 o_inside
);

    localparam int CW  = VALUE_WIDTH + 1;
    localparam int PW  = CW + VALUE_WIDTH;
    localparam int BW  = CW + 1;
    localparam int AW  = BW + FRAC_BITS;
    localparam int SW  = ((PW > AW) ? PW : AW) + 2;

    logic signed [CW-1:0] w_coef;
    logic signed [VALUE_WIDTH-1:0] w_cen;
    logic signed [PW-1:0] n_prod;
    logic signed [BW-1:0] n_bias;

    logic signed [PW-1:0] r_prod;
    logic signed [BW-1:0] r_bias;
    t_mac_ctrl            r_tag;
    logic signed [SW-1:0] r_acc;
    logic                 r_inside;

    logic signed [SW-1:0] w_base;
    logic signed [SW-1:0] w_sum;
    logic                 w_cull;

    // issue stage: one product per cycle, bias D + r alongside
    always_comb begin
        w_coef = $signed(i_row[i_ctrl.sel]);
        w_cen  = $signed(i_centre[i_ctrl.sel]);
        n_prod = PW'(w_coef) * PW'(w_cen);
        n_bias = BW'($signed(i_row[COEF_COUNT-1])) + $signed({3'b000, i_radius});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= '0;
        end else begin
            r_tag <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.issue) begin
            r_prod <= n_prod;
            r_bias <= n_bias;
        end
    end

    // accumulate stage; bias carries 2*FRAC_BITS alignment after the shift
    always_comb begin
        w_base = r_tag.first ? (SW'(r_bias) <<< FRAC_BITS) : r_acc;
        w_sum  = w_base + SW'(r_prod);
        w_cull = w_sum[SW-1] || (w_sum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (r_tag.issue) begin
            r_acc <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inside <= 1'b1;
        end else if (i_ctrl.start) begin
            r_inside <= 1'b1;
        end else if (r_tag.issue && r_tag.last && w_cull) begin
            r_inside <= 1'b0;
        end
    end

    assign o_inside = r_inside;

endmodule

// ----- hdl/frustum_sphere_cull.sv -----
// Frustum culling of bounding spheres against six clip planes.
//
// Input stream (s_*): one word is either a matrix line load or a sphere test,
// chosen by s_tuser[0]. A load of line i stores coefficient i of all six
// planes (e3 +/- e0, e1, e2) and gives no result. A test returns one output
// word whose bit 0 is 1 when the sphere is not fully behind any plane.
//
// Sequencing: a load is written into the plane store as it is accepted
// and the block stays ready. A test runs one shared multiplier over 6
// planes x 3 axes, one product a cycle, then a drain step and a final
// step that posts the result; the next word is taken only once the
// sequencer is back in idle, so tests are not overlapped.
//
// Output stall: the result sits in an output register; the next word is
// accepted meanwhile, and a following test waits in its final step until
// that register is free.
//
// Reset (i_rst_n low, synchronous): all plane coefficients clear to zero,
// sequencer idle, no output pending.
module frustum_sphere_cull
    import fsc_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // elem_0, elem_1, elem_2, elem_3, centre_x, centre_y, centre_z,
    // sphere_radius (31 bits), one zero pad bit
    input  logic [S_TDATA_W-1:0] s_tdata,
    // action, line_index
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // in_frustum, seven zero pad bits
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [PLANE_IDX_W-1:0] r_plane, n_plane;
    logic [STEP_W-1:0]      r_step,  n_step;

    logic [AXIS_STEPS-1:0][VALUE_WIDTH-1:0] r_centre;
    logic [VALUE_WIDTH-2:0]                 r_radius;
    logic                                   r_m_tvalid;
    logic                                   r_m_result;

    logic                                   w_accept;
    logic                                   w_action;
    logic [LINE_W-1:0]                      w_line;
    logic [3:0][VALUE_WIDTH-1:0]            w_elem;
    logic [COEF_COUNT-1:0][VALUE_WIDTH:0]   w_row;
    logic                                   w_inside;
    logic                                   w_post;
    t_mac_ctrl                              w_ctrl;

    assign s_tready = (r_state == ST_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_action = s_tuser[0];
    assign w_line   = s_tuser[2:1];

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_elem[k] = s_tdata[k*FIELD_W +: VALUE_WIDTH];
        end
    end

    // capture sphere at acceptance
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_action == ACT_TEST)) begin
            for (int k = 0; k < AXIS_STEPS; k++) begin
                r_centre[k] <= s_tdata[(4+k)*FIELD_W +: VALUE_WIDTH];
            end
            r_radius <= s_tdata[7*FIELD_W +: (VALUE_WIDTH-1)];
        end
    end

    // sequencer: plane outer, axis inner
    always_comb begin
        n_state = r_state;
        n_plane = r_plane;
        n_step  = r_step;
        w_ctrl  = '0;
        w_post  = 1'b0;
        w_ctrl.sel = r_step;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_action == ACT_TEST)) begin
                    w_ctrl.start = 1'b1;
                    n_state = ST_RUN;
                    n_plane = '0;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                w_ctrl.issue = 1'b1;
                w_ctrl.first = (r_step == '0);
                w_ctrl.last  = (r_step == STEP_W'(AXIS_STEPS-1));
                if (w_ctrl.last) begin
                    n_step = '0;
                    if (r_plane == PLANE_IDX_W'(PLANE_COUNT-1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        n_plane = r_plane + 1'b1;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!r_m_tvalid || m_tready) begin
                    w_post  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_plane <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_plane <= n_plane;
            r_step  <= n_step;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_post) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_post) begin
            r_m_result <= w_inside;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {{(M_TDATA_W-1){1'b0}}, r_m_result};

    fsc_plane_store #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_accept && (w_action == ACT_LOAD)),
        .i_line  (w_line),
        .i_elem  (w_elem),
        .i_plane (r_plane),
        .o_row   (w_row)
    );

    fsc_mac #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_row    (w_row),
        .i_centre (r_centre),
        .i_radius (r_radius),
        .o_inside (w_inside)
    );

`ifndef SYNTHESIS
    a_test_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_TEST)) |=> (r_state == ST_RUN))
        else $error("test word did not start the sequencer");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_action == ACT_LOAD)) |=> (r_state == ST_IDLE))
        else $error("load word left the idle state");

    a_counter_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN) |->
        ((r_plane < PLANE_IDX_W'(PLANE_COUNT)) && (r_step < STEP_W'(AXIS_STEPS))))
        else $error("sequencer counter out of range");

    a_post_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_tvalid) |-> $past(r_state == ST_FIN))
        else $error("result posted outside final step");
`endif

endmodule
